[hdl/rgcl_pkg.sv]
// Shared types, constants and control store for the rectilinear grid cell lookup.
// Used by the top level and by its port checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rgcl_pkg;

    // Table sizes.
    localparam int MaxCellsAxis    = 16;
    localparam int MaxSpeedEntries = 4096;

    // Field widths.
    localparam int FUNC_W  = 3;
    localparam int SLOT_W  = 12;
    localparam int VAL_W   = 32;
    localparam int CELL_W  = 4;
    localparam int CNT_W   = 5;
    localparam int AXIS_W  = 2;
    localparam int SEC_W   = $clog2(MaxCellsAxis + 1);
    localparam int SPD_AW  = $clog2(MaxSpeedEntries);
    localparam int BMEM_AW = AXIS_W + SEC_W;
    localparam int BMEM_DEPTH = 3 * (1 << SEC_W);
    localparam int T_W     = 9;
    localparam int IDX_W   = 14;

    // Port widths.
    localparam int S_TDATA_W = 144;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 240;
    localparam int M_TUSER_W = 1;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = CNT_W;

    // Item kinds carried in s_tuser.
    localparam logic [FUNC_W-1:0] FUNC_WR_X     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_Y     = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_WR_Z     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_WR_SPEED = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_QUERY    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_CELLS_X = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_CELLS_Y = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_CELLS_Z = 2'd2;

    // Axis codes.
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // Micro-operations.
    localparam logic [2:0] OP_WAIT      = 3'd0;
    localparam logic [2:0] OP_SCAN      = 3'd1;
    localparam logic [2:0] OP_MUL1      = 3'd2;
    localparam logic [2:0] OP_MUL2      = 3'd3;
    localparam logic [2:0] OP_READ      = 3'd4;
    localparam logic [2:0] OP_DONE_OK   = 3'd5;
    localparam logic [2:0] OP_DONE_FAIL = 3'd6;

    // Program addresses.
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_WAIT   = 4'd0;
    localparam logic [PC_W-1:0] PC_SCAN_X = 4'd1;
    localparam logic [PC_W-1:0] PC_SCAN_Y = 4'd2;
    localparam logic [PC_W-1:0] PC_SCAN_Z = 4'd3;
    localparam logic [PC_W-1:0] PC_MUL1   = 4'd4;
    localparam logic [PC_W-1:0] PC_MUL2   = 4'd5;
    localparam logic [PC_W-1:0] PC_READ   = 4'd6;
    localparam logic [PC_W-1:0] PC_OK     = 4'd7;
    localparam logic [PC_W-1:0] PC_FAIL   = 4'd8;

    // One control word: the operation, the axis it works on and its jump target.
    typedef struct packed {
        logic [2:0]        op;
        logic [AXIS_W-1:0] axis;
        logic [PC_W-1:0]   target;
    } uword_t;

    // The control store.
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            PC_WAIT:   w = '{op: OP_WAIT,      axis: AXIS_X, target: PC_SCAN_X};
            PC_SCAN_X: w = '{op: OP_SCAN,      axis: AXIS_X, target: PC_FAIL};
            PC_SCAN_Y: w = '{op: OP_SCAN,      axis: AXIS_Y, target: PC_FAIL};
            PC_SCAN_Z: w = '{op: OP_SCAN,      axis: AXIS_Z, target: PC_FAIL};
            PC_MUL1:   w = '{op: OP_MUL1,      axis: AXIS_X, target: PC_MUL2};
            PC_MUL2:   w = '{op: OP_MUL2,      axis: AXIS_X, target: PC_READ};
            PC_READ:   w = '{op: OP_READ,      axis: AXIS_X, target: PC_FAIL};
            PC_OK:     w = '{op: OP_DONE_OK,   axis: AXIS_X, target: PC_WAIT};
            PC_FAIL:   w = '{op: OP_DONE_FAIL, axis: AXIS_X, target: PC_WAIT};
            default:   w = '{op: OP_WAIT,      axis: AXIS_X, target: PC_SCAN_X};
        endcase
        return w;
    endfunction

    // Cell counts above the table size are clamped to it.
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        return (c > CNT_W'(MaxCellsAxis)) ? CNT_W'(MaxCellsAxis) : c;
    endfunction

endpackage

`default_nettype wire

[hdl/rectilinear_grid_cell_lookup.sv]
// A query scans the x, y and z bounds in turn, one section per cycle, then forms the
// linear index and reads the speed; a miss in a scan skips the remaining steps.
// Loads are taken one per cycle while no query is in flight; queries are not
// overlapped, as the sequencer takes no new item until a query has left its done step.
// Reset (aresetn low, synchronous): counts to 1, sequencer to its wait step, no
// result pending. Table contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the rectilinear grid cell lookup. Depends on rgcl_pkg.
module rectilinear_grid_cell_lookup (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Input item channel.
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    // s_tdata from bit 0: slot[11:0], entry_value[43:12], point_x[75:44],
    // point_y[107:76], point_z[139:108], zero fill[143:140].
    input  wire logic [rgcl_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: func[2:0].
    input  wire logic [rgcl_pkg::S_TUSER_W-1:0]   s_tuser,
    // Result channel.
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata from bit 0: cell_x[3:0], cell_y[7:4], cell_z[11:8], x_low[43:12],
    // x_high[75:44], y_low[107:76], y_high[139:108], z_low[171:140],
    // z_high[203:172], speed[235:204], zero fill[239:236].
    output      logic [rgcl_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: status[0].
    output      logic [rgcl_pkg::M_TUSER_W-1:0]   m_tuser,
    // Configuration write port.
    input  wire logic                             cfg_wr_en,
    input  wire logic [rgcl_pkg::CFG_AW-1:0]      cfg_addr,
    input  wire logic [rgcl_pkg::CFG_DW-1:0]      cfg_wdata
);

    // ------------------------------------------------------------------
    // Input field unpacking.
    // ------------------------------------------------------------------
    logic [rgcl_pkg::FUNC_W-1:0] in_func;
    logic [rgcl_pkg::SLOT_W-1:0] in_slot;
    logic [rgcl_pkg::VAL_W-1:0]  in_value;
    logic [rgcl_pkg::VAL_W-1:0]  in_px;
    logic [rgcl_pkg::VAL_W-1:0]  in_py;
    logic [rgcl_pkg::VAL_W-1:0]  in_pz;
    logic                        s_accept;

    assign in_func  = s_tuser;
    assign in_slot  = s_tdata[11:0];
    assign in_value = s_tdata[43:12];
    assign in_px    = s_tdata[75:44];
    assign in_py    = s_tdata[107:76];
    assign in_pz    = s_tdata[139:108];

    // ------------------------------------------------------------------
    // Sequencer state. The program counter walks the control store; the
    // section counter is the loop index of the scan steps.
    // ------------------------------------------------------------------
    logic [rgcl_pkg::PC_W-1:0]  pc_reg, pc_next;
    logic [rgcl_pkg::SEC_W-1:0] sec_reg, sec_next;
    rgcl_pkg::uword_t           uw, uw_next;

    assign uw      = rgcl_pkg::ucode(pc_reg);
    assign uw_next = rgcl_pkg::ucode(pc_next);

    // Only the wait step takes items, so loads never disturb a query in flight.
    assign s_tready = (uw.op == rgcl_pkg::OP_WAIT);
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [rgcl_pkg::CNT_W-1:0] cnt_x_reg, cnt_y_reg, cnt_z_reg;
    logic [rgcl_pkg::CNT_W-1:0] eff_x, eff_y, eff_z, cur_cnt;

    assign eff_x = rgcl_pkg::eff_count(cnt_x_reg);
    assign eff_y = rgcl_pkg::eff_count(cnt_y_reg);
    assign eff_z = rgcl_pkg::eff_count(cnt_z_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_x_reg <= rgcl_pkg::CNT_W'(1);
            cnt_y_reg <= rgcl_pkg::CNT_W'(1);
            cnt_z_reg <= rgcl_pkg::CNT_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                rgcl_pkg::CFG_CELLS_X: cnt_x_reg <= cfg_wdata;
                rgcl_pkg::CFG_CELLS_Y: cnt_y_reg <= cfg_wdata;
                rgcl_pkg::CFG_CELLS_Z: cnt_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Query point and per-axis results of the scans.
    // ------------------------------------------------------------------
    logic [rgcl_pkg::VAL_W-1:0]  pt_reg   [0:2];
    logic [rgcl_pkg::CELL_W-1:0] cell_reg [0:2];
    logic [rgcl_pkg::VAL_W-1:0]  lo_reg   [0:2];
    logic [rgcl_pkg::VAL_W-1:0]  hi_reg   [0:2];
    logic [rgcl_pkg::VAL_W-1:0]  cur_pt;

    // Count and coordinate of the axis that the current step scans.
    always_comb begin
        unique case (uw.axis)
            rgcl_pkg::AXIS_X: begin
                cur_cnt = eff_x;
                cur_pt  = pt_reg[0];
            end
            rgcl_pkg::AXIS_Y: begin
                cur_cnt = eff_y;
                cur_pt  = pt_reg[1];
            end
            default: begin
                cur_cnt = eff_z;
                cur_pt  = pt_reg[2];
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Bound memory: all three axes in one array, row = {axis, section}.
    // Both ends of a section are read in the same cycle. The read address comes
    // from the next-step logic so that the data lines up with sec_reg.
    // ------------------------------------------------------------------
    logic [rgcl_pkg::VAL_W-1:0]   bmem [0:rgcl_pkg::BMEM_DEPTH-1];
    logic [rgcl_pkg::VAL_W-1:0]   bd_lo_reg, bd_hi_reg;
    logic [rgcl_pkg::BMEM_AW-1:0] rd_addr_lo, rd_addr_hi;
    logic                         bound_wr;

    assign rd_addr_lo = {uw_next.axis, sec_next};
    assign rd_addr_hi = {uw_next.axis, sec_next + rgcl_pkg::SEC_W'(1)};
    assign bound_wr   = s_accept && (in_func <= rgcl_pkg::FUNC_WR_Z)
                        && (in_slot <= rgcl_pkg::SLOT_W'(rgcl_pkg::MaxCellsAxis));

    always_ff @(posedge aclk) begin
        if (bound_wr) begin
            bmem[{in_func[rgcl_pkg::AXIS_W-1:0], in_slot[rgcl_pkg::SEC_W-1:0]}] <= in_value;
        end
        bd_lo_reg <= bmem[rd_addr_lo];
        bd_hi_reg <= bmem[rd_addr_hi];
    end

    // ------------------------------------------------------------------
    // Speed memory: one write port for loads, one registered read port
    // addressed by the linear cell index.
    // ------------------------------------------------------------------
    logic [rgcl_pkg::VAL_W-1:0] spd_mem [0:rgcl_pkg::MaxSpeedEntries-1];
    logic [rgcl_pkg::VAL_W-1:0] spd_rd_reg;
    logic [rgcl_pkg::IDX_W-1:0] idx_reg;
    logic [rgcl_pkg::T_W-1:0]   t_reg;
    logic                       speed_wr;

    assign speed_wr = s_accept && (in_func == rgcl_pkg::FUNC_WR_SPEED)
                      && ({1'b0, in_slot} < (rgcl_pkg::SLOT_W + 1)'(rgcl_pkg::MaxSpeedEntries));

    always_ff @(posedge aclk) begin
        if (speed_wr) begin
            spd_mem[in_slot[rgcl_pkg::SPD_AW-1:0]] <= in_value;
        end
        spd_rd_reg <= spd_mem[idx_reg[rgcl_pkg::SPD_AW-1:0]];
    end

    // ------------------------------------------------------------------
    // Step control. A scan step stays on itself while the section does not
    // enclose the coordinate and sections remain; a match moves on to the
    // next step and an exhausted or empty axis jumps to the failure step.
    // ------------------------------------------------------------------
    logic match, found, out_free, idx_bad;

    assign match = ($signed(bd_lo_reg) <= $signed(cur_pt))
                   && ($signed(cur_pt) <= $signed(bd_hi_reg));
    assign out_free = !m_tvalid || m_tready;
    assign idx_bad  = (idx_reg >= rgcl_pkg::IDX_W'(rgcl_pkg::MaxSpeedEntries));

    always_comb begin
        pc_next  = pc_reg;
        sec_next = '0;
        found    = 1'b0;
        unique case (uw.op)
            rgcl_pkg::OP_WAIT: begin
                if (s_accept && (in_func == rgcl_pkg::FUNC_QUERY)) begin
                    pc_next = uw.target;
                end
            end
            rgcl_pkg::OP_SCAN: begin
                if (cur_cnt == '0) begin
                    pc_next = uw.target;
                end else if (match) begin
                    pc_next = pc_reg + rgcl_pkg::PC_W'(1);
                    found   = 1'b1;
                end else if (sec_reg == cur_cnt - rgcl_pkg::CNT_W'(1)) begin
                    pc_next = uw.target;
                end else begin
                    sec_next = sec_reg + rgcl_pkg::SEC_W'(1);
                end
            end
            rgcl_pkg::OP_MUL1, rgcl_pkg::OP_MUL2: begin
                pc_next = uw.target;
            end
            rgcl_pkg::OP_READ: begin
                pc_next = idx_bad ? uw.target : (pc_reg + rgcl_pkg::PC_W'(1));
            end
            rgcl_pkg::OP_DONE_OK, rgcl_pkg::OP_DONE_FAIL: begin
                if (out_free) begin
                    pc_next = uw.target;
                end
            end
            default: begin
                pc_next = rgcl_pkg::PC_WAIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= rgcl_pkg::PC_WAIT;
            sec_reg <= '0;
        end else begin
            pc_reg  <= pc_next;
            sec_reg <= sec_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers driven by the current control word.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept && (in_func == rgcl_pkg::FUNC_QUERY)) begin
            pt_reg[0] <= in_px;
            pt_reg[1] <= in_py;
            pt_reg[2] <= in_pz;
        end
        if (found) begin
            cell_reg[uw.axis] <= sec_reg[rgcl_pkg::CELL_W-1:0];
            lo_reg[uw.axis]   <= bd_lo_reg;
            hi_reg[uw.axis]   <= bd_hi_reg;
        end
        // Linear index in two multiply steps: (z*cy + y), then that *cx + x.
        if (uw.op == rgcl_pkg::OP_MUL1) begin
            t_reg <= rgcl_pkg::T_W'(cell_reg[2]) * rgcl_pkg::T_W'(eff_y)
                     + rgcl_pkg::T_W'(cell_reg[1]);
        end
        if (uw.op == rgcl_pkg::OP_MUL2) begin
            idx_reg <= rgcl_pkg::IDX_W'(t_reg) * rgcl_pkg::IDX_W'(eff_x)
                       + rgcl_pkg::IDX_W'(cell_reg[0]);
        end
    end

    // ------------------------------------------------------------------
    // Output register. A finished result waits here while the sequencer
    // returns to its wait step and takes further items.
    // ------------------------------------------------------------------
    logic                             m_tvalid_reg;
    logic [rgcl_pkg::M_TDATA_W-1:0]   m_tdata_reg;
    logic [rgcl_pkg::M_TUSER_W-1:0]   m_tuser_reg;
    logic                             load_ok, load_fail;

    assign load_ok   = (uw.op == rgcl_pkg::OP_DONE_OK) && out_free;
    assign load_fail = (uw.op == rgcl_pkg::OP_DONE_FAIL) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_ok || load_fail) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ok) begin
            m_tuser_reg <= 1'b0;
            m_tdata_reg <= {4'b0, spd_rd_reg, hi_reg[2], lo_reg[2], hi_reg[1], lo_reg[1],
                            hi_reg[0], lo_reg[0], cell_reg[2], cell_reg[1], cell_reg[0]};
        end else if (load_fail) begin
            // A miss (point outside the mesh or index beyond the speed table) reports zeros in every field.
            m_tuser_reg <= 1'b1;
            m_tdata_reg <= '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

[hdl/rgcl_checker.sv]
// Port-level checks for the rectilinear grid cell lookup, bound to its top level.
// Depends on rgcl_pkg and rectilinear_grid_cell_lookup.
`timescale 1ns / 1ps
`default_nettype none

module rgcl_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [rgcl_pkg::S_TUSER_W-1:0]  s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [rgcl_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic [rgcl_pkg::M_TUSER_W-1:0]  m_tuser
);

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A miss reports all-zero fields.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("miss result carries nonzero fields");

    // A query occupies the sequencer for at least the following cycle.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == rgcl_pkg::FUNC_QUERY) |=> !s_tready)
        else $error("ready right after a query transfer");

    // After a table load or other non-query item the input is ready again in the next cycle.
    a_load_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != rgcl_pkg::FUNC_QUERY) |=> s_tready)
        else $error("not ready after a load transfer");

endmodule

bind rectilinear_grid_cell_lookup rgcl_checker u_rgcl_checker (.*);

`default_nettype wire
